[rtl/cfd_pkg.sv]
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the CRC-8 byte update for the COBS frame
// decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam int unsigned CRC_TOP_BIT  = 7;
    localparam logic [7:0] CODE_FULL     = 8'hFF;
    localparam logic [7:0] DELIMITER     = 8'h00;
    localparam logic [8:0] LEN_FIELD_MAX = 9'd511;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_ERR   = 2'd1,
        STATUS_SHORT     = 2'd2,
        STATUS_MALFORMED = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [7:0]    out_byte;
        logic [7:0]    byte_position;
        logic          frame_end;
        logic [8:0]    frame_length;
        frame_status_t frame_status;
    } result_t;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] rem, input logic [7:0] d);
        logic [7:0] r;
        r = rem ^ d;
        for (int b = 0; b < 8; b++) begin
            if (r[CRC_TOP_BIT]) begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

[rtl/cfd_decode.sv]
// ----------------------------------------------------------------------------
// cfd_decode
// Per-byte COBS decode state, CRC-8 accumulation and result formation.
// ----------------------------------------------------------------------------
module cfd_decode #(
    parameter int unsigned MAX_FRAME_BYTES = cfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,      // process rx_byte this cycle
    input  logic [7:0]       rx_byte,
    output logic             res_valid, // this byte yields an item
    output cfd_pkg::result_t res
);

    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned LW = (CW > 9) ? CW : 9;

    logic [7:0]    group_left_reg,   group_left_next;
    logic          group_full_reg,   group_full_next;
    logic          expect_code_reg,  expect_code_next;
    logic          zero_pending_reg, zero_pending_next;
    logic [7:0]    held_byte_reg,    held_byte_next;
    logic          held_valid_reg,   held_valid_next;
    logic [7:0]    crc_reg,          crc_next;
    logic [CW-1:0] count_reg,        count_next;
    logic          fault_reg,        fault_next;

    logic          take;
    logic [7:0]    take_data;
    logic [7:0]    left_dec;
    logic [LW-1:0] cnt_ext;

    assign cnt_ext = LW'(count_reg);

    always_comb begin
        group_left_next   = group_left_reg;
        group_full_next   = group_full_reg;
        expect_code_next  = expect_code_reg;
        zero_pending_next = zero_pending_reg;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg;
        crc_next          = crc_reg;
        count_next        = count_reg;
        fault_next        = fault_reg;
        res_valid         = 1'b0;
        res               = '0;
        take              = 1'b0;
        take_data         = rx_byte;
        left_dec          = group_left_reg - {7'd0, (group_left_reg != 8'd0)};

        if (rx_byte == cfd_pkg::DELIMITER) begin
            // end item, then back to the reset state
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
            if (cnt_ext > LW'(cfd_pkg::LEN_FIELD_MAX)) begin
                res.frame_length = cfd_pkg::LEN_FIELD_MAX;
            end else begin
                res.frame_length = cnt_ext[8:0];
            end
            if (fault_reg || !expect_code_reg) begin
                res.frame_status = cfd_pkg::STATUS_MALFORMED;
            end else if (cnt_ext < LW'(2)) begin
                res.frame_status = cfd_pkg::STATUS_SHORT;
            end else if (crc_reg != 8'd0) begin
                res.frame_status = cfd_pkg::STATUS_CRC_ERR;
            end else begin
                res.frame_status = cfd_pkg::STATUS_OK;
            end
            group_left_next   = 8'd0;
            group_full_next   = 1'b0;
            expect_code_next  = 1'b1;
            zero_pending_next = 1'b0;
            held_byte_next    = 8'd0;
            held_valid_next   = 1'b0;
            crc_next          = 8'd0;
            count_next        = '0;
            fault_next        = 1'b0;
        end else if (expect_code_reg) begin
            // code byte; the owed zero of the previous group is decoded now
            take              = zero_pending_reg;
            take_data         = 8'd0;
            zero_pending_next = 1'b0;
            group_left_next   = rx_byte - 8'd1;
            group_full_next   = (rx_byte == cfd_pkg::CODE_FULL);
            if (rx_byte == 8'd1) begin
                expect_code_next  = 1'b1;
                zero_pending_next = 1'b1;
            end else begin
                expect_code_next = 1'b0;
            end
        end else begin
            take            = 1'b1;
            group_left_next = left_dec;
            if (left_dec == 8'd0) begin
                expect_code_next  = 1'b1;
                zero_pending_next = !group_full_reg;
            end
        end

        if (take && !fault_reg) begin
            if (count_reg >= CW'(MAX_FRAME_BYTES)) begin
                fault_next = 1'b1;
            end else begin
                // previous byte goes out; the newest stays held (CRC byte never shown)
                if (held_valid_reg && (count_reg != '0)) begin
                    res_valid         = 1'b1;
                    res.out_byte      = held_byte_reg;
                    res.byte_position = 8'(cnt_ext - LW'(1));
                end
                held_byte_next  = take_data;
                held_valid_next = 1'b1;
                crc_next        = cfd_pkg::crc8_byte(crc_reg, take_data);
                count_next      = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_left_reg   <= 8'd0;
            group_full_reg   <= 1'b0;
            expect_code_reg  <= 1'b1;
            zero_pending_reg <= 1'b0;
            held_byte_reg    <= 8'd0;
            held_valid_reg   <= 1'b0;
            crc_reg          <= 8'd0;
            count_reg        <= '0;
            fault_reg        <= 1'b0;
        end else if (step) begin
            group_left_reg   <= group_left_next;
            group_full_reg   <= group_full_next;
            expect_code_reg  <= expect_code_next;
            zero_pending_reg <= zero_pending_next;
            held_byte_reg    <= held_byte_next;
            held_valid_reg   <= held_valid_next;
            crc_reg          <= crc_next;
            count_reg        <= count_next;
            fault_reg        <= fault_next;
        end
    end

endmodule

[rtl/cobs_frame_decoder_crc8.sv]
// ----------------------------------------------------------------------------
// cobs_frame_decoder_crc8
// Streaming COBS frame decoder with CRC-8 (poly 0x07) frame check.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one encoded link byte per item; 0x00 is the frame delimiter.
//   m_ channel: data items (decoded bytes, one behind, so the trailing CRC
//     byte is never shown) and one end item per delimiter (m_tlast = 1)
//     carrying the frame length and status in frame_length / m_tuser.
//   Status: 0 ok, 1 CRC mismatch, 2 fewer than two bytes, 3 malformed or
//     longer than MAX_FRAME_BYTES (no data items past the limit).
//   Path: an accepted item sits in the input register, is decoded there, and
//     its result is loaded into the result register and shown on m_.
//   Throughput: one item per cycle while not stalled; the per-byte decode and
//     CRC update are combinational between the input and result registers.
//   Stall: the input register keeps taking an item while a result waits in
//     the output register; an item that yields no result still moves on.
//     s_tready falls only when the held byte makes a result, the result
//     register is full and m_tready is low.
//   Reset: synchronous, active low; clears the frame state (expecting a code
//     byte) and empties both registers.
// ----------------------------------------------------------------------------
module cobs_frame_decoder_crc8 #(
    parameter int unsigned MAX_FRAME_BYTES = cfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [15:8] byte_position,
                                   // [24:16] frame_length, [31:25] zero
    output logic        m_tlast,   // frame_end
    output logic [1:0]  m_tuser    // frame_status
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic             out_valid_reg;
    cfd_pkg::result_t out_reg;

    logic             advance;
    logic             res_valid;
    cfd_pkg::result_t res;

    cfd_decode #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .res_valid(res_valid),
        .res      (res)
    );

    // a byte moves on unless it makes a result and the result slot stays full
    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.frame_length, out_reg.byte_position, out_reg.out_byte};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.frame_status;

endmodule
